>>> design/gpv_pkg.sv
package gpv_pkg;

  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChDash  = 8'h2D;

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_OPEN,
    MODE_NEG,
    MODE_BODY
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_PIPE,
    ERR_TRIPLE_STAR,
    ERR_DOUBLE_STAR,
    ERR_EMPTY_CLASS,
    ERR_EMPTY_NEGATED,
    ERR_REVERSED_RANGE,
    ERR_UNCLOSED
  } err_t;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic       pattern_valid;
    logic [2:0] error_code;
  } out_word_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] skip;
    err_t       err;
  } scan_t;

  typedef struct packed {
    logic [7:0] look0;
    logic [7:0] look1;
    logic [1:0] look_count;
    scan_t      scan;
    logic [1:0] star_run;
    logic       pipe_seen;
    logic       triple_seen;
  } state_t;

  function automatic scan_t class_byte(scan_t s, logic [7:0] c0, logic h1, logic [7:0] c1,
                                       logic h2, logic [7:0] c2);
    scan_t r;
    r = s;
    r.mode = MODE_BODY;
    if (c0 == ChClose) begin
      r.mode = MODE_OUT;
    end else if (h1 && c1 == ChDash && h2 && c2 != ChClose) begin
      if ($signed(c0) > $signed(c2)) begin
        r.err = ERR_REVERSED_RANGE;
      end else begin
        r.skip = 2'd2;
      end
    end
    return r;
  endfunction

  function automatic scan_t scan_pos(scan_t s, logic [7:0] c0, logic h1, logic [7:0] c1,
                                     logic h2, logic [7:0] c2);
    scan_t r;
    r = s;
    if (s.skip != 2'd0) begin
      r.skip = s.skip - 2'd1;
    end else if (s.err == ERR_NONE) begin
      case (s.mode)
        MODE_OUT: begin
          if (c0 == ChStar && h1 && c1 == ChStar) begin
            if (h2 && c2 != ChSlash) begin
              r.err = ERR_DOUBLE_STAR;
            end else begin
              r.skip = h2 ? 2'd2 : 2'd1;
            end
          end else if (c0 == ChOpen) begin
            r.mode = MODE_OPEN;
          end
        end
        MODE_OPEN: begin
          if (c0 == ChClose) begin
            r.err = ERR_EMPTY_CLASS;
          end else if (c0 == ChCaret || c0 == ChBang) begin
            r.mode = MODE_NEG;
          end else begin
            r = class_byte(s, c0, h1, c1, h2, c2);
          end
        end
        MODE_NEG: begin
          if (c0 == ChClose) begin
            r.err = ERR_EMPTY_NEGATED;
          end else begin
            r = class_byte(s, c0, h1, c1, h2, c2);
          end
        end
        default: begin
          r = class_byte(s, c0, h1, c1, h2, c2);
        end
      endcase
    end
    return r;
  endfunction

endpackage

>>> design/gpv_step.sv
module gpv_step (
  input  gpv_pkg::state_t    state,
  input  gpv_pkg::in_word_t  word,
  output gpv_pkg::state_t    state_next,
  output gpv_pkg::out_word_t result
);
  import gpv_pkg::*;

  logic [1:0] n;
  logic [1:0] run_inc;
  logic [7:0] b;
  logic [7:0] buf0;
  logic [7:0] buf1;
  logic [1:0] m;
  logic       pipe_now;
  logic       triple_now;
  scan_t      s1;
  scan_t      s2;
  scan_t      s3;
  err_t       code;
  state_t     cont;

  assign b = word.pattern_byte;
  assign n = (state.look_count > 2'd2) ? 2'd2 : state.look_count;
  assign run_inc = (state.star_run == 2'd3) ? 2'd3 : state.star_run + 2'd1;
  assign pipe_now = state.pipe_seen || (b == ChPipe);
  assign triple_now = state.triple_seen || (b == ChStar && run_inc == 2'd3);

  always_comb begin
    s1 = state.scan;
    buf0 = state.look0;
    buf1 = state.look1;
    m = n + 2'd1;
    case (n)
      2'd0: begin
        buf0 = b;
      end
      2'd1: begin
        buf1 = b;
      end
      default: begin
        s1 = scan_pos(state.scan, state.look0, 1'b1, state.look1, 1'b1, b);
        buf0 = state.look1;
        buf1 = b;
        m = 2'd2;
      end
    endcase
  end

  always_comb begin
    s2 = scan_pos(s1, buf0, m == 2'd2, (m == 2'd2) ? buf1 : 8'h00, 1'b0, 8'h00);
    s3 = (m == 2'd2) ? scan_pos(s2, buf1, 1'b0, 8'h00, 1'b0, 8'h00) : s2;
    if (pipe_now) begin
      code = ERR_PIPE;
    end else if (triple_now) begin
      code = ERR_TRIPLE_STAR;
    end else if (s3.err != ERR_NONE) begin
      code = s3.err;
    end else if (s3.mode != MODE_OUT) begin
      code = ERR_UNCLOSED;
    end else begin
      code = ERR_NONE;
    end
  end

  always_comb begin
    cont.look0 = buf0;
    cont.look1 = buf1;
    cont.look_count = m;
    cont.scan = s1;
    cont.star_run = (b == ChStar) ? run_inc : 2'd0;
    cont.pipe_seen = pipe_now;
    cont.triple_seen = triple_now;
  end

  assign state_next = word.is_last ? '0 : cont;
  assign result.pattern_valid = (code == ERR_NONE);
  assign result.error_code = code;

endmodule

>>> design/gpv_out_reg.sv
module gpv_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gpv_pkg::out_word_t load_word,
  output logic               free,
  output logic               result_valid,
  input  logic               result_ready,
  output gpv_pkg::out_word_t result_word
);
  import gpv_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

>>> design/glob_pattern_validator_top.sv
// A last byte's result passes from the input register into the output register.
// Throughput: one pattern byte per cycle; a result waiting in the output register
// stalls only a following last byte, set by the single output register.
// Reset: synchronous, active high; clears the scan state, the input valid flag and
// the output valid flag; the first byte after reset starts a new pattern.
module glob_pattern_validator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  gpv_pkg::in_word_t  byte_word,
  output logic               result_valid,
  input  logic               result_ready,
  output gpv_pkg::out_word_t result_word
);
  import gpv_pkg::*;

  logic      hold_valid;
  in_word_t  hold_word;
  state_t    state;
  state_t    state_next;
  out_word_t step_result;
  logic      out_free;
  logic      fire;

  assign fire = hold_valid && (!hold_word.is_last || out_free);
  assign byte_ready = !hold_valid || fire;

  gpv_step u_step (
    .state      (state),
    .word       (hold_word),
    .state_next (state_next),
    .result     (step_result)
  );

  gpv_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && hold_word.is_last),
    .load_word    (step_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      state <= '0;
    end else begin
      if (byte_valid && byte_ready) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        state <= state_next;
      end
    end
    if (byte_valid && byte_ready) begin
      hold_word <= byte_word;
    end
  end

endmodule

>>> design/gpv_checker.sv
module gpv_checker (
  input logic               clk,
  input logic               rst,
  input logic               byte_valid,
  input logic               byte_ready,
  input gpv_pkg::in_word_t  byte_word,
  input logic               result_valid,
  input logic               result_ready,
  input gpv_pkg::out_word_t result_word
);
  import gpv_pkg::*;

  // With no result waiting, nothing can hold up the input register.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> byte_ready)
    else $error("byte_ready low while no result is pending");

  a_valid_matches_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.pattern_valid == (result_word.error_code == ERR_NONE)))
    else $error("pattern_valid disagrees with error_code");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("stalled result word changed");

endmodule

bind glob_pattern_validator_top gpv_checker u_gpv_checker (.*);
